// File: hw/rtl/lbrw_pkg.sv
// ----------------------------------------------------------------------------
// Link busy ratio package
// Widths, codes and sizing shared by the sliding-window busy ratio meter.
// ----------------------------------------------------------------------------
package lbrw_pkg;

	localparam int HIST_DEPTH = 64;
	localparam int HIST_AW = $clog2(HIST_DEPTH);
	localparam int CNT_W = HIST_AW + 1;

	localparam int RATIO_FRAC_BITS = 16;
	localparam int RATIO_W = RATIO_FRAC_BITS + 1;
	localparam int STEP_W = $clog2(RATIO_FRAC_BITS + 1);

	localparam int TIME_W = 64;
	localparam int WIN_W = 40;
	localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(1000000);

	localparam int OP_W = 2;
	localparam logic [OP_W-1:0] OP_START = 2'd0;
	localparam logic [OP_W-1:0] OP_STOP = 2'd1;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

	localparam int ERR_W = 2;
	localparam logic [ERR_W-1:0] ERR_NONE = 2'd0;
	localparam logic [ERR_W-1:0] ERR_FUTURE = 2'd1;
	localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd2;

endpackage

// File: hw/rtl/link_busy_ratio_window.sv
// ----------------------------------------------------------------------------
// Link busy ratio over a sliding window
// Records busy periods of a link in a history ring and reports the busy
// fraction of the last window as a Q1.16 ratio on each query.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Contents
//  in        sink       in_valid / in_stall  op, now_ns
//  out       source     out_valid / out_stall busy_ratio, overloaded, error_code
//  cfg       sink       cfg_valid / cfg_ready window_ns
//
// A start, an ignored stop or an unused op is handled in the idle state. A stop
// computes the duration, evicts the oldest entry when the ring is full, then
// writes the new entry. A query reads and drops each expired entry, adds the
// open period, clamps the total and runs a restoring divide; a total that
// reaches the window skips the 16 divide steps. The single shared 65-bit adder
// serves all of these. Reset clears all control state; the history RAM is never cleared.
// A result stalled at the output holds the block in its final query state.
// ----------------------------------------------------------------------------
module link_busy_ratio_window (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [lbrw_pkg::OP_W-1:0]           op,
	input  logic [lbrw_pkg::TIME_W-1:0]         now_ns,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [lbrw_pkg::RATIO_W-1:0]        busy_ratio,
	output logic                                overloaded,
	output logic [lbrw_pkg::ERR_W-1:0]          error_code,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lbrw_pkg::WIN_W-1:0]          window_ns
);
	import lbrw_pkg::*;

	typedef enum logic [12:0] {
		ST_IDLE     = 13'b0000000000001,
		ST_STOP_DUR = 13'b0000000000010,
		ST_EV_RD    = 13'b0000000000100,
		ST_EV_SUB   = 13'b0000000001000,
		ST_STOP_WR  = 13'b0000000010000,
		ST_Q_RD     = 13'b0000000100000,
		ST_Q_CHK    = 13'b0000001000000,
		ST_Q_SUB    = 13'b0000010000000,
		ST_Q_OPEN   = 13'b0000100000000,
		ST_Q_ADD    = 13'b0001000000000,
		ST_Q_CLAMP  = 13'b0010000000000,
		ST_DIV      = 13'b0100000000000,
		ST_FIN      = 13'b1000000000000
	} state_t;

	state_t                state_q;
	logic [WIN_W-1:0]      window_q;
	logic                  busy_q;
	logic [TIME_W-1:0]     open_q;
	logic [TIME_W-1:0]     sum_q;
	logic [TIME_W-1:0]     now_q;
	logic [TIME_W-1:0]     span_q;
	logic [TIME_W-1:0]     total_q;
	logic [HIST_AW-1:0]    head_q;
	logic [CNT_W-1:0]      count_q;
	logic [ERR_W-1:0]      sticky_q;
	logic [WIN_W-1:0]      rem_q;
	logic [RATIO_W-1:0]    quot_q;
	logic [STEP_W-1:0]     step_q;
	logic                  over_q;
	logic                  out_valid_q;
	logic [RATIO_W-1:0]    ratio_q;
	logic                  ovl_q;
	logic [ERR_W-1:0]      err_q;

	logic [WIN_W-1:0]      win_eff;
	logic [TIME_W-1:0]     win_ext;
	logic [TIME_W-1:0]     alu_a;
	logic [TIME_W-1:0]     alu_b;
	logic                  alu_sub;
	logic [TIME_W:0]       alu_res;
	logic                  ram_wr;
	logic                  ram_rd;
	logic [2*TIME_W-1:0]   ram_rdata;
	logic [TIME_W-1:0]     rd_end;
	logic [TIME_W-1:0]     rd_len;
	logic                  ring_full;
	logic                  out_free;

	assign win_eff = (window_q == '0) ? WIN_W'(1) : window_q;
	assign win_ext = TIME_W'(win_eff);
	assign rd_end = ram_rdata[2*TIME_W-1:TIME_W];
	assign rd_len = ram_rdata[TIME_W-1:0];
	assign ring_full = (count_q == CNT_W'(HIST_DEPTH));
	assign out_free = !out_valid_q || !out_stall;

	assign in_stall = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign busy_ratio = ratio_q;
	assign overloaded = ovl_q;
	assign error_code = err_q;

	// Shared adder: bit 64 is the carry of an add or the borrow of a subtract.
	always_comb begin
		alu_a = now_q;
		alu_b = open_q;
		alu_sub = 1'b1;
		unique case (state_q)
			ST_EV_SUB, ST_Q_SUB: begin
				alu_a = sum_q;
				alu_b = rd_len;
			end
			ST_STOP_WR, ST_Q_ADD: begin
				alu_a = sum_q;
				alu_b = span_q;
				alu_sub = 1'b0;
			end
			ST_Q_CHK: begin
				alu_b = rd_end;
			end
			ST_DIV: begin
				alu_a = TIME_W'({rem_q, 1'b0});
				alu_b = win_ext;
			end
			default: begin
			end
		endcase
	end

	assign alu_res = {1'b0, alu_a} + ({1'b0, alu_b} ^ {(TIME_W + 1){alu_sub}})
		+ (TIME_W + 1)'(alu_sub);

	assign ram_wr = (state_q == ST_STOP_WR);
	assign ram_rd = (state_q == ST_EV_RD) || (state_q == ST_Q_RD);

	lbrw_ram #(
		.WIDTH(2 * TIME_W),
		.DEPTH(HIST_DEPTH)
	) u_hist (
		.clk     (clk),
		.wr_en   (ram_wr),
		.wr_addr (head_q + count_q[HIST_AW-1:0]),
		.wr_data ({now_q, span_q}),
		.rd_en   (ram_rd),
		.rd_addr (head_q),
		.rd_data (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			window_q <= WINDOW_RESET;
			busy_q <= 1'b0;
			open_q <= '0;
			sum_q <= '0;
			head_q <= '0;
			count_q <= '0;
			sticky_q <= ERR_NONE;
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != ST_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_valid) begin
						window_q <= window_ns;
					end
					if (in_valid) begin
						now_q <= now_ns;
						unique case (op)
							OP_START: begin
								if (!busy_q) begin
									open_q <= now_ns;
									busy_q <= 1'b1;
								end
							end
							OP_STOP: begin
								if (busy_q) begin
									state_q <= ST_STOP_DUR;
								end
							end
							OP_QUERY: begin
								state_q <= ST_Q_RD;
							end
							default: begin
							end
						endcase
					end
				end
				ST_STOP_DUR: begin
					if (alu_res[TIME_W]) begin
						span_q <= '0;
						if (sticky_q == ERR_NONE) begin
							sticky_q <= ERR_FUTURE;
						end
					end else begin
						span_q <= alu_res[TIME_W-1:0];
					end
					state_q <= ring_full ? ST_EV_RD : ST_STOP_WR;
				end
				ST_EV_RD: begin
					state_q <= ST_EV_SUB;
				end
				ST_EV_SUB: begin
					sum_q <= alu_res[TIME_W-1:0];
					head_q <= head_q + HIST_AW'(1);
					count_q <= count_q - CNT_W'(1);
					if (sticky_q == ERR_NONE) begin
						sticky_q <= ERR_OVERFLOW;
					end
					state_q <= ST_STOP_WR;
				end
				ST_STOP_WR: begin
					sum_q <= alu_res[TIME_W-1:0];
					count_q <= count_q + CNT_W'(1);
					busy_q <= 1'b0;
					state_q <= ST_IDLE;
				end
				ST_Q_RD: begin
					state_q <= (count_q == '0) ? ST_Q_OPEN : ST_Q_CHK;
				end
				ST_Q_CHK: begin
					state_q <= (alu_res[TIME_W-1:0] >= win_ext) ? ST_Q_SUB : ST_Q_OPEN;
				end
				ST_Q_SUB: begin
					sum_q <= alu_res[TIME_W-1:0];
					head_q <= head_q + HIST_AW'(1);
					count_q <= count_q - CNT_W'(1);
					state_q <= ST_Q_RD;
				end
				ST_Q_OPEN: begin
					span_q <= '0;
					if (busy_q) begin
						if (alu_res[TIME_W]) begin
							if (sticky_q == ERR_NONE) begin
								sticky_q <= ERR_FUTURE;
							end
						end else begin
							span_q <= alu_res[TIME_W-1:0];
						end
					end
					state_q <= ST_Q_ADD;
				end
				ST_Q_ADD: begin
					total_q <= alu_res[TIME_W] ? '1 : alu_res[TIME_W-1:0];
					state_q <= ST_Q_CLAMP;
				end
				ST_Q_CLAMP: begin
					over_q <= (total_q > win_ext);
					quot_q <= '0;
					rem_q <= total_q[WIN_W-1:0];
					step_q <= STEP_W'(RATIO_FRAC_BITS);
					if (total_q >= win_ext) begin
						quot_q <= RATIO_W'(1) << RATIO_FRAC_BITS;
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (alu_res[TIME_W]) begin
						rem_q <= {rem_q[WIN_W-2:0], 1'b0};
						quot_q <= {quot_q[RATIO_W-2:0], 1'b0};
					end else begin
						rem_q <= alu_res[WIN_W-1:0];
						quot_q <= {quot_q[RATIO_W-2:0], 1'b1};
					end
					step_q <= step_q - STEP_W'(1);
					if (step_q == STEP_W'(1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						ratio_q <= quot_q;
						ovl_q <= over_q;
						err_q <= sticky_q;
						sticky_q <= ERR_NONE;
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(HIST_DEPTH))
		else $error("History count exceeds the ring depth.");

	a_rem_below_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (TIME_W'(rem_q) < win_ext))
		else $error("Divide remainder is not below the window.");

	a_fin_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_free) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("Finished query did not present its beat.");

	a_ratio_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (ratio_q <= (RATIO_W'(1) << RATIO_FRAC_BITS)))
		else $error("Busy ratio exceeds one.");

endmodule

// File: hw/rtl/lbrw_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with a registered read.
// ----------------------------------------------------------------------------
module lbrw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: bench/link_busy_ratio_window_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Busy ratio checker
// Watches the input, output and configuration channels of the sliding-window
// busy ratio meter, keeps its own model of the history ring and the window,
// predicts the result beat of every accepted query and compares each result
// beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module link_busy_ratio_window_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic [lbrw_pkg::OP_W-1:0]    op,
	input  logic [lbrw_pkg::TIME_W-1:0]  now_ns,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic [lbrw_pkg::RATIO_W-1:0] busy_ratio,
	input  logic                         overloaded,
	input  logic [lbrw_pkg::ERR_W-1:0]   error_code,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic [lbrw_pkg::WIN_W-1:0]   window_ns,
	output int                           fail_count,
	output int                           pending
);

	import lbrw_pkg::*;

	localparam int EXP_DEPTH = 64;

	typedef struct packed {
		logic [RATIO_W-1:0] ratio;
		logic               over;
		logic [ERR_W-1:0]   err;
	} ratio_beat_t;

	ratio_beat_t expected_ratios [EXP_DEPTH];
	int          exp_wr;
	int          exp_rd;

	logic [WIN_W-1:0]   win_cfg;
	logic               link_busy;
	logic [TIME_W-1:0]  open_start;
	logic [TIME_W-1:0]  busy_total;
	logic [TIME_W-1:0]  end_mem [HIST_DEPTH];
	logic [TIME_W-1:0]  len_mem [HIST_DEPTH];
	logic [HIST_AW-1:0] head;
	logic [CNT_W-1:0]   count;
	logic [ERR_W-1:0]   sticky;

	function automatic logic [RATIO_W-1:0] q16_fraction(input logic [TIME_W-1:0] t,
			input logic [TIME_W-1:0] w);
		logic [TIME_W-1:0]  rem;
		logic [RATIO_W-1:0] q;
		if (t >= w) begin
			return RATIO_W'(1) << RATIO_FRAC_BITS;
		end
		rem = t;
		q = '0;
		for (int i = 0; i < RATIO_FRAC_BITS; i++) begin
			rem = rem << 1;
			q = q << 1;
			if (rem >= w) begin
				rem = rem - w;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	task automatic note_fault(input logic [ERR_W-1:0] code);
		if (sticky == ERR_NONE) begin
			sticky = code;
		end
	endtask

	task automatic drop_oldest();
		busy_total = busy_total - len_mem[head];
		head = head + HIST_AW'(1);
		count = count - CNT_W'(1);
	endtask

	task automatic take_beat(input logic [OP_W-1:0] o, input logic [TIME_W-1:0] now);
		logic [TIME_W-1:0]  w;
		logic [TIME_W-1:0]  total;
		logic [TIME_W-1:0]  open_len;
		logic [TIME_W-1:0]  dur;
		logic [HIST_AW-1:0] slot;
		logic               over;
		ratio_beat_t        r;
		w = (win_cfg == '0) ? TIME_W'(1) : TIME_W'(win_cfg);
		case (o)
			OP_START: begin
				if (!link_busy) begin
					open_start = now;
					link_busy = 1'b1;
				end
			end
			OP_STOP: begin
				if (link_busy) begin
					dur = '0;
					if (open_start > now) begin
						note_fault(ERR_FUTURE);
					end else begin
						dur = now - open_start;
					end
					if (count >= CNT_W'(HIST_DEPTH)) begin
						drop_oldest();
						note_fault(ERR_OVERFLOW);
					end
					slot = head + count[HIST_AW-1:0];
					end_mem[slot] = now;
					len_mem[slot] = dur;
					count = count + CNT_W'(1);
					busy_total = busy_total + dur;
					link_busy = 1'b0;
				end
			end
			OP_QUERY: begin
				while (count != '0 && (now - end_mem[head]) >= w) begin
					drop_oldest();
				end
				total = busy_total;
				if (link_busy) begin
					if (open_start > now) begin
						note_fault(ERR_FUTURE);
					end else begin
						open_len = now - open_start;
						total = (total > ~open_len) ? '1 : total + open_len;
					end
				end
				over = total > w;
				if (over) begin
					total = w;
				end
				r.ratio = q16_fraction(total, w);
				r.over = over;
				r.err = sticky;
				sticky = ERR_NONE;
				expected_ratios[exp_wr % EXP_DEPTH] = r;
				exp_wr++;
			end
			default: ;
		endcase
	endtask

	task automatic check_beat();
		ratio_beat_t want;
		if (exp_wr == exp_rd) begin
			if (fail_count < 10) begin
				$display("unexpected result beat: ratio %0d overloaded %0b error %0d",
					busy_ratio, overloaded, error_code);
			end
			fail_count++;
		end else begin
			want = expected_ratios[exp_rd % EXP_DEPTH];
			exp_rd++;
			if (busy_ratio !== want.ratio || overloaded !== want.over ||
					error_code !== want.err) begin
				if (fail_count < 10) begin
					$display("result mismatch: expected %0d/%0b/%0d, got %0d/%0b/%0d",
						want.ratio, want.over, want.err,
						busy_ratio, overloaded, error_code);
				end
				fail_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_cfg = WINDOW_RESET;
			link_busy = 1'b0;
			open_start = '0;
			busy_total = '0;
			head = '0;
			count = '0;
			sticky = ERR_NONE;
			exp_wr = 0;
			exp_rd = 0;
		end else begin
			if (out_valid && !out_stall) begin
				check_beat();
			end
			if (cfg_valid && cfg_ready) begin
				win_cfg = window_ns;
			end
			if (in_valid && !in_stall) begin
				take_beat(op, now_ns);
			end
		end
		pending = exp_wr - exp_rd;
	end

endmodule

// File: bench/link_busy_ratio_window_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Busy ratio meter testbench
// Drives start, stop and query beats into the sliding-window busy ratio meter
// under several window settings and idling patterns, with one long output
// hold-off, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module link_busy_ratio_window_tb;

	import lbrw_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 250;
	localparam int HOLD_CYCLES = 400;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [OP_W-1:0]    op;
	logic [TIME_W-1:0]  now_ns;
	logic               out_valid;
	logic               out_stall;
	logic [RATIO_W-1:0] busy_ratio;
	logic               overloaded;
	logic [ERR_W-1:0]   error_code;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [WIN_W-1:0]   window_ns;

	int fail_count;
	int pending_results;
	int tx_idle_pct;
	int rx_idle_pct;
	logic hold_req;
	int hold_left;
	logic hold_done;
	logic [TIME_W-1:0] t_ns;

	link_busy_ratio_window dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.now_ns     (now_ns),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.busy_ratio (busy_ratio),
		.overloaded (overloaded),
		.error_code (error_code),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.window_ns  (window_ns)
	);

	link_busy_ratio_window_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.now_ns     (now_ns),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.busy_ratio (busy_ratio),
		.overloaded (overloaded),
		.error_code (error_code),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.window_ns  (window_ns),
		.fail_count (fail_count),
		.pending    (pending_results)
	);

	initial begin
		clk = 1'b0;
		forever begin
			#6 clk = ~clk;
		end
	end

	initial begin
		#(20_000_000);
		$display("FAIL");
		$finish;
	end

	// The receiver stalls at random, apart from one long hold-off that keeps the
	// block stalled on a result while the sender keeps offering beats.
	initial begin
		out_stall = 1'b0;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < rx_idle_pct);
			end
		end
	end

	task automatic send_beat(input logic [OP_W-1:0] o, input logic [TIME_W-1:0] t);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			op <= OP_W'($urandom);
			now_ns <= {$urandom, $urandom};
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		now_ns <= t;
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_window(input logic [WIN_W-1:0] w);
		cfg_valid <= 1'b1;
		window_ns <= w;
		forever begin
			@(posedge clk);
			if (cfg_ready) break;
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input logic [WIN_W-1:0] w, input int n_items, input int mode,
			input logic high_base, input logic with_hold);
		int          sent;
		int          pick;
		logic [31:0] span;
		logic [1:0]  noise_op;
		drain();
		write_window(w);
		case (mode)
			0: begin
				tx_idle_pct = 24;
				rx_idle_pct = 85;
			end
			1: begin
				tx_idle_pct = 85;
				rx_idle_pct = 24;
			end
			default: begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
		endcase
		span = (w > 40'd4000000) ? 32'd1000000 : w[31:0] / 4 + 2;
		t_ns = high_base ? {$urandom, $urandom} : TIME_W'($urandom);
		sent = 0;
		while (sent < n_items) begin
			if (with_hold && sent >= 20) begin
				hold_req <= 1'b1;
			end
			pick = $urandom_range(99);
			if (pick < 70) begin
				send_beat(OP_START, t_ns);
				t_ns = t_ns + TIME_W'($urandom_range(span));
				send_beat(OP_STOP, t_ns);
				t_ns = t_ns + TIME_W'($urandom_range(span));
				sent += 2;
				if ($urandom_range(99) < 45) begin
					send_beat(OP_QUERY, t_ns);
					sent++;
				end
			end else if (pick < 80) begin
				send_beat(OP_START, t_ns);
				t_ns = t_ns + TIME_W'($urandom_range(span));
				send_beat(OP_QUERY, t_ns);
				sent += 2;
			end else if (pick < 88) begin
				send_beat(OP_QUERY, t_ns);
				t_ns = t_ns + TIME_W'($urandom_range(span)) * TIME_W'(8);
				sent++;
			end else begin
				noise_op = 2'($urandom_range(3));
				if ($urandom_range(1)) begin
					send_beat(noise_op, {$urandom, $urandom});
				end else begin
					send_beat(noise_op, t_ns - TIME_W'($urandom_range(span)));
				end
				sent++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_START;
		now_ns = '0;
		cfg_valid = 1'b0;
		window_ns = '0;
		hold_req = 1'b0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed beats under the reset window of one million nanoseconds.
		send_beat(OP_QUERY, 64'd0);
		send_beat(OP_STOP, 64'd10);
		send_beat(OP_START, 64'd100);
		send_beat(OP_START, 64'd200);
		send_beat(OP_QUERY, 64'd50);
		send_beat(OP_QUERY, 64'd250100);
		send_beat(OP_STOP, 64'd500100);
		send_beat(OP_QUERY, 64'd600000);
		send_beat(OP_UNUSED, '1);
		send_beat(OP_START, 64'd700000);
		send_beat(OP_STOP, 64'd2100000);
		send_beat(OP_QUERY, 64'd2100000);
		send_beat(OP_START, 64'd5000000);
		send_beat(OP_STOP, 64'd4000000);
		send_beat(OP_QUERY, 64'd4000000);
		send_beat(OP_START, 64'd0);
		send_beat(OP_STOP, '1);
		send_beat(OP_START, 64'd0);
		send_beat(OP_STOP, '1);
		send_beat(OP_START, 64'd0);
		send_beat(OP_QUERY, '1);
		send_beat(OP_STOP, 64'd1);
		send_beat(OP_QUERY, 64'd0);

		run_phase(40'd1000, 113, 0, 1'b0, 1'b0);
		run_phase('1, 113, 0, 1'b1, 1'b0);
		run_phase('0, 113, 1, 1'b0, 1'b0);
		run_phase(40'd50000, 113, 1, 1'b1, 1'b0);
		run_phase(40'd1, 113, 2, 1'b0, 1'b1);
		run_phase({8'($urandom), 32'($urandom)}, 113, 2, 1'b1, 1'b0);

		drain();
		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/lbrw_pkg.sv
hw/rtl/lbrw_ram.sv
hw/rtl/link_busy_ratio_window.sv
bench/link_busy_ratio_window_checker.sv
bench/link_busy_ratio_window_tb.sv
